>>> rtl/skms_pkg.sv
// Shared widths, request codes and the sequencer microprogram for the key table.
`default_nettype none
package skms_pkg;

  // fixed port widths
  localparam int REQ_W        = 2;
  localparam int KEY_PORT_W   = 16;
  localparam int COUNT_PORT_W = 7;

  // default sizing
  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // microprogram steps
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE   = 4'd0;
  localparam step_t S_CLR    = 4'd1;
  localparam step_t S_APP    = 4'd2;
  localparam step_t S_A_CHK  = 4'd3;
  localparam step_t S_A_CMP  = 4'd4;
  localparam step_t S_A_WR   = 4'd5;
  localparam step_t S_A_FULL = 4'd6;
  localparam step_t S_QRY    = 4'd7;
  localparam step_t S_Q_CHK  = 4'd8;
  localparam step_t S_Q_CMP  = 4'd9;
  localparam step_t S_RESP   = 4'd10;
  localparam int    NUM_STEPS = 11;

  // datapath actions
  typedef logic [3:0] act_t;
  localparam act_t ACT_NOP       = 4'd0;
  localparam act_t ACT_CLEAR     = 4'd1;
  localparam act_t ACT_LOAD_POS  = 4'd2;
  localparam act_t ACT_READ_PREV = 4'd3;
  localparam act_t ACT_SHIFT_GT  = 4'd4;
  localparam act_t ACT_WRITE_KEY = 4'd5;
  localparam act_t ACT_SET_FULL  = 4'd6;
  localparam act_t ACT_LOAD_RNG  = 4'd7;
  localparam act_t ACT_READ_MID  = 4'd8;
  localparam act_t ACT_NARROW    = 4'd9;
  localparam act_t ACT_POST      = 4'd10;

  // sequencing conditions: jump to target when true, else fall through (the wait conditions hold instead)
  typedef logic [2:0] cond_t;
  localparam cond_t C_NEXT    = 3'd0;
  localparam cond_t C_JUMP    = 3'd1;
  localparam cond_t C_WAIT_IN = 3'd2;  // hold until an item arrives, then dispatch
  localparam cond_t C_FULL    = 3'd3;
  localparam cond_t C_POS_Z   = 3'd4;
  localparam cond_t C_GT      = 3'd5;
  localparam cond_t C_EMPTY   = 3'd6;  // search range empty
  localparam cond_t C_OUT_OK  = 3'd7;  // hold until result register is free

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ucode_t;

  localparam ucode_t UCODE [NUM_STEPS] = '{
    '{ACT_NOP,       C_WAIT_IN, S_IDLE},    // S_IDLE
    '{ACT_CLEAR,     C_JUMP,    S_RESP},    // S_CLR
    '{ACT_LOAD_POS,  C_FULL,    S_A_FULL},  // S_APP
    '{ACT_READ_PREV, C_POS_Z,   S_A_WR},    // S_A_CHK
    '{ACT_SHIFT_GT,  C_GT,      S_A_CHK},   // S_A_CMP
    '{ACT_WRITE_KEY, C_JUMP,    S_RESP},    // S_A_WR
    '{ACT_SET_FULL,  C_JUMP,    S_RESP},    // S_A_FULL
    '{ACT_LOAD_RNG,  C_NEXT,    S_IDLE},    // S_QRY
    '{ACT_READ_MID,  C_EMPTY,   S_RESP},    // S_Q_CHK
    '{ACT_NARROW,    C_GT,      S_Q_CHK},   // S_Q_CMP (cond reused: not equal loops)
    '{ACT_POST,      C_OUT_OK,  S_IDLE}     // S_RESP
  };

endpackage
`default_nettype wire

>>> rtl/skms_req_if.sv
// Request channel: request kind and key.
`default_nettype none
interface skms_req_if;
  logic                               valid;
  logic                               ready;
  logic [skms_pkg::REQ_W-1:0]         req_type;
  logic [skms_pkg::KEY_PORT_W-1:0]    key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface
`default_nettype wire

>>> rtl/skms_rsp_if.sv
// Response channel: found flag, full flag and entry count.
`default_nettype none
interface skms_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic                               full_error;
  logic [skms_pkg::COUNT_PORT_W-1:0]  entry_count;

  modport source (output valid, output found, output full_error, output entry_count,
                  input ready);
  modport sink   (input valid, input found, input full_error, input entry_count,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/sorted_key_membership_search.sv
// Top level: sorted key table with insertion-sort append and binary-search query.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------
//  req     | in  | valid / ready | req_type[1:0], key[15:0]
//  rsp     | out | valid / ready | found, full_error, entry_count[6:0]
//
// Per item: a clear empties the table; a query probes the binary-search midpoint until a
//   hit or an empty range; an append shifts each larger entry up by one place, starting
//   from the end of the table, then writes the key; a full append sets the full flag
//   instead. The shift loop is set by the one read/one write port of the key RAM.
// Reset (rst, synchronous) empties the table and drops any pending result; RAM
//   contents are not cleared, only entries below the count are ever read.
// A new item is taken while the previous result still waits in the output register;
//   the sequencer only stalls in its final step if that register is still full.
`default_nettype none
module sorted_key_membership_search #(
  parameter int CAPACITY = skms_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = skms_pkg::KEY_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  skms_req_if.sink   req,
  skms_rsp_if.source rsp
);
  import skms_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // sequencer
  step_t  step;
  step_t  step_next;
  ucode_t uw;

  // datapath registers
  logic [KEY_BITS-1:0] key_r;
  logic [CNT_W-1:0]    count;
  logic [ADDR_W-1:0]   pos;
  logic [CNT_W-1:0]    lo;
  logic [CNT_W-1:0]    hi;
  logic [ADDR_W-1:0]   mid;
  logic                found_r;
  logic                full_r;

  // RAM port signals
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [KEY_BITS-1:0] ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [KEY_BITS-1:0] ram_rdata;

  logic [KEY_PORT_W+KEY_BITS-1:0]    key_wide;
  logic [KEY_BITS-1:0]               key_in;
  logic [CNT_W-1:0]                  mid_calc;
  logic                              accept;
  logic                              out_free;
  logic                              rd_gt;
  logic                              rd_eq;
  logic [COUNT_PORT_W+CNT_W-1:0]     count_wide;

  // only the low KEY_BITS of the key port count; zero-extend when wider
  assign key_wide = {{KEY_BITS{1'b0}}, req.key};
  assign key_in   = key_wide[KEY_BITS-1:0];

  assign count_wide = {{COUNT_PORT_W{1'b0}}, count};

  assign uw       = UCODE[step];
  assign req.ready = (step == S_IDLE);
  assign accept   = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;

  assign mid_calc = lo + ((hi - lo) >> 1);
  assign rd_gt    = ram_rdata > key_r;
  assign rd_eq    = ram_rdata == key_r;

  // next step
  always_comb begin
    step_next = step;
    unique case (uw.cond)
      C_NEXT:    step_next = step + step_t'(1);
      C_JUMP:    step_next = uw.target;
      C_WAIT_IN: begin
        if (accept) begin
          unique case (req.req_type)
            REQ_CLEAR:  step_next = S_CLR;
            REQ_APPEND: step_next = S_APP;
            REQ_QUERY:  step_next = S_QRY;
            default:    step_next = S_RESP;   // unused code: plain status reply
          endcase
        end
      end
      C_FULL:    step_next = (count >= CAP_CNT) ? uw.target : step + step_t'(1);
      C_POS_Z:   step_next = (pos == '0) ? uw.target : step + step_t'(1);
      C_GT: begin
        // append: larger entry shifted, go again; query: a miss narrows and loops
        if (uw.act == ACT_NARROW) begin
          step_next = rd_eq ? step + step_t'(1) : uw.target;
        end else begin
          step_next = rd_gt ? uw.target : step + step_t'(1);
        end
      end
      C_EMPTY:   step_next = (lo >= hi) ? uw.target : step + step_t'(1);
      C_OUT_OK:  step_next = out_free ? uw.target : step;
      default:   step_next = S_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = key_r;
    ram_re    = 1'b0;
    ram_raddr = pos - ADDR_W'(1);
    unique case (uw.act)
      ACT_READ_PREV: ram_re = 1'b1;
      ACT_READ_MID: begin
        ram_re    = 1'b1;
        ram_raddr = mid_calc[ADDR_W-1:0];
      end
      ACT_SHIFT_GT: begin
        ram_we    = rd_gt;
        ram_wdata = ram_rdata;
      end
      ACT_WRITE_KEY: ram_we = 1'b1;
      default: ;
    endcase
  end

  skms_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      step <= step_next;
      if (uw.act == ACT_CLEAR) begin
        count <= '0;
      end else if (uw.act == ACT_WRITE_KEY) begin
        count <= count + CNT_W'(1);
      end
      if (uw.act == ACT_POST && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r   <= key_in;
      found_r <= 1'b0;
      full_r  <= 1'b0;
    end
    unique case (uw.act)
      ACT_LOAD_POS: pos <= count[ADDR_W-1:0];
      ACT_SHIFT_GT: begin
        if (rd_gt) begin
          pos <= pos - ADDR_W'(1);
        end
      end
      ACT_SET_FULL: full_r <= 1'b1;
      ACT_LOAD_RNG: begin
        lo <= '0;
        hi <= count;
      end
      ACT_READ_MID: mid <= mid_calc[ADDR_W-1:0];
      ACT_NARROW: begin
        if (rd_eq) begin
          found_r <= 1'b1;
        end else if (rd_gt) begin
          hi <= CNT_W'(mid);
        end else begin
          lo <= CNT_W'(mid) + CNT_W'(1);
        end
      end
      ACT_POST: begin
        if (out_free) begin
          rsp.found       <= found_r;
          rsp.full_error  <= full_r;
          rsp.entry_count <= count_wide[COUNT_PORT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  a_full_only_at_cap: assert property (@(posedge clk) disable iff (rst)
    full_r && step != S_IDLE |-> count == CAP_CNT)
    else $error("full flag with room left");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> step != S_IDLE)
    else $error("accepted item not started");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (step == S_A_CHK || step == S_A_CMP) |-> CNT_W'(pos) < count + CNT_W'(1))
    else $error("insert position beyond count");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.found && rsp.full_error))
    else $error("found and full both set");

endmodule
`default_nettype wire

>>> rtl/skms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module skms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire
